// ----- rtl/deque_with_erase_by_value_core_macros.svh -----
// ----------------------------------------------------------------------------
// deque_with_erase_by_value_core_macros.svh
// Assertion shorthands for the deque core. They expect clk and rst in scope.
// ----------------------------------------------------------------------------
`ifndef DEQUE_WITH_ERASE_BY_VALUE_CORE_MACROS_SVH
`define DEQUE_WITH_ERASE_BY_VALUE_CORE_MACROS_SVH

// Condition that holds at every clock edge outside reset
`define DQE_ASSERT_ALWAYS(label, cond, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication
`define DQE_ASSERT_IMPL(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication
`define DQE_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/dqerase_pkg.sv -----
// ----------------------------------------------------------------------------
// dqerase_pkg
// Shared types and codes of the deque core: request and response transaction
// structs, operation and status codes, controller states.
// ----------------------------------------------------------------------------
package dqerase_pkg;

  // Operation codes
  localparam logic [2:0] OP_PUSH_BACK  = 3'd0;
  localparam logic [2:0] OP_PUSH_FRONT = 3'd1;
  localparam logic [2:0] OP_POP_BACK   = 3'd2;
  localparam logic [2:0] OP_POP_FRONT  = 3'd3;
  localparam logic [2:0] OP_ERASE      = 3'd4;

  // Status codes
  localparam logic [1:0] ST_OK        = 2'd0;
  localparam logic [1:0] ST_EMPTY     = 2'd1;
  localparam logic [1:0] ST_FULL      = 2'd2;
  localparam logic [1:0] ST_NOT_FOUND = 2'd3;

  // Request transaction
  typedef struct packed {
    logic [2:0]  opcode;
    logic [31:0] value;
  } req_t;

  // Response transaction
  typedef struct packed {
    logic [31:0] popped;
    logic [1:0]  status;
    logic [4:0]  occupancy;
  } rsp_t;

  // Controller states
  typedef enum logic [2:0] {
    S_IDLE,
    S_EXEC,
    S_POP,
    S_SCAN,
    S_SHIFT,
    S_DONE
  } state_t;

endpackage

// ----- rtl/dqerase_ram.sv -----
// ----------------------------------------------------------------------------
// dqerase_ram
// Generic single-write, single-read synchronous RAM with registered read data.
// ----------------------------------------------------------------------------
module dqerase_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // Write port and registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

// ----- rtl/deque_with_erase_by_value_core.sv -----
// ----------------------------------------------------------------------------
// deque_with_erase_by_value_core
// Bounded double-ended queue with push/pop at both ends and erase by value.
// ----------------------------------------------------------------------------
// Usage:
//   Request channel (req_valid, req_stall, req) carries one operation per
//   transaction: push back, push front, pop back, pop front or erase value.
//   Response channel (rsp_valid, rsp_stall, rsp) returns exactly one
//   transaction per request: popped word, status and occupancy after it.
//   Entries live in one synchronous RAM ring buffer with registered read data.
//   A request is taken only while the controller is idle; one at a time.
//   Push and unused codes go from the exec to the done state; a pop of a
//   non-empty queue passes the pop state, which captures the read word; an
//   erase of a non-empty queue scans and, on a match, closes the gap, which
//   together visit each held entry once, one per cycle, through the single
//   RAM read/write port pair. The next request is taken in the cycle after
//   the result enters the output register, so requests do not overlap.
//   The response sits in an output register; while rsp_stall is high it is
//   held, and a finished result waits in the done state until the register
//   frees up. Reset empties the queue; no RAM clearing pass is needed.
// ----------------------------------------------------------------------------
`include "deque_with_erase_by_value_core_macros.svh"

module deque_with_erase_by_value_core
  import dqerase_pkg::*;
#(
  parameter int CAPACITY   = 16,
  parameter int DATA_WIDTH = 32
) (
  input  logic clk,
  input  logic rst,
  input  logic req_valid,
  output logic req_stall,
  input  req_t req,
  output logic rsp_valid,
  input  logic rsp_stall,
  output rsp_t rsp
);

  localparam int IDX_W = $clog2(CAPACITY);
  localparam int CNT_W = $clog2(CAPACITY + 1);
  localparam int SUM_W = CNT_W + 1;
  localparam logic [IDX_W-1:0] LAST_IDX = IDX_W'(CAPACITY - 1);

  // Ring slot of a logical position counted from the front
  function automatic logic [IDX_W-1:0] slot_of(input logic [IDX_W-1:0] frnt,
                                               input logic [SUM_W-1:0] pos_in);
    logic [SUM_W-1:0] s;
    s = SUM_W'(frnt) + pos_in;
    if (s >= SUM_W'(CAPACITY)) begin
      s = s - SUM_W'(CAPACITY);
    end
    return s[IDX_W-1:0];
  endfunction

  state_t state, state_next;
  logic [IDX_W-1:0]      front;
  logic [CNT_W-1:0]      count;
  logic [CNT_W-1:0]      pos;
  logic [2:0]            cmd_op;
  logic [DATA_WIDTH-1:0] cmd_val;
  logic [31:0]           res_popped;
  logic [1:0]            res_status;

  logic                  ram_we;
  logic [IDX_W-1:0]      ram_waddr;
  logic [DATA_WIDTH-1:0] ram_wdata;
  logic [IDX_W-1:0]      ram_raddr;
  logic [DATA_WIDTH-1:0] ram_rdata;

  logic [63:0]           req_val64;
  logic [63:0]           rd64;
  logic [31:0]           count32;
  logic [SUM_W-1:0]      cnt_s;
  logic [SUM_W-1:0]      pos1;
  logic [SUM_W-1:0]      pos2;
  logic [IDX_W-1:0]      front_inc;
  logic [IDX_W-1:0]      front_dec;
  logic                  full;
  logic                  empty;
  logic                  match;
  logic                  scan_last;
  logic                  shift_more;
  logic                  out_free;

  // Entry storage
  dqerase_ram #(
    .WIDTH (DATA_WIDTH),
    .DEPTH (CAPACITY)
  ) u_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Status and position helpers
  assign req_val64  = 64'(req.value);
  assign rd64       = 64'(ram_rdata);
  assign count32    = 32'(count);
  assign cnt_s      = SUM_W'(count);
  assign pos1       = SUM_W'(pos) + SUM_W'(1);
  assign pos2       = SUM_W'(pos) + SUM_W'(2);
  assign front_inc  = (front == LAST_IDX) ? '0 : front + IDX_W'(1);
  assign front_dec  = (front == '0) ? LAST_IDX : front - IDX_W'(1);
  assign full       = (count == CNT_W'(CAPACITY));
  assign empty      = (count == '0);
  assign match      = (ram_rdata == cmd_val);
  assign scan_last  = (pos1 >= cnt_s);
  assign shift_more = (pos2 < cnt_s);
  assign out_free   = !rsp_valid || !rsp_stall;
  assign req_stall  = (state != S_IDLE);

  // Next state
  always_comb begin
    state_next = state;
    case (state)
      S_IDLE: begin
        if (req_valid) state_next = S_EXEC;
      end
      S_EXEC: begin
        case (cmd_op)
          OP_POP_BACK, OP_POP_FRONT: state_next = empty ? S_DONE : S_POP;
          OP_ERASE:                  state_next = empty ? S_DONE : S_SCAN;
          default:                   state_next = S_DONE;
        endcase
      end
      S_POP: state_next = S_DONE;
      S_SCAN: begin
        if (scan_last) begin
          state_next = S_DONE;
        end else if (match) begin
          state_next = S_SHIFT;
        end
      end
      S_SHIFT: begin
        if (!shift_more) state_next = S_DONE;
      end
      S_DONE: begin
        if (out_free) state_next = S_IDLE;
      end
      default: state_next = S_IDLE;
    endcase
  end

  // RAM access per state
  always_comb begin
    ram_we    = 1'b0;
    ram_waddr = front;
    ram_wdata = cmd_val;
    ram_raddr = front;
    case (state)
      S_EXEC: begin
        case (cmd_op)
          OP_PUSH_BACK: begin
            ram_we    = !full;
            ram_waddr = slot_of(front, cnt_s);
          end
          OP_PUSH_FRONT: begin
            ram_we    = !full;
            ram_waddr = front_dec;
          end
          OP_POP_BACK: ram_raddr = slot_of(front, cnt_s - SUM_W'(1));
          default:     ram_raddr = front;
        endcase
      end
      S_SCAN: ram_raddr = slot_of(front, pos1);
      S_SHIFT: begin
        ram_we    = 1'b1;
        ram_waddr = slot_of(front, SUM_W'(pos));
        ram_wdata = ram_rdata;
        ram_raddr = slot_of(front, pos2);
      end
      default: ;
    endcase
  end

  // Control and result registers
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      front     <= '0;
      count     <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      // done state reloads the output register itself
      if (rsp_valid && !rsp_stall && (state != S_DONE)) rsp_valid <= 1'b0;
      case (state)
        S_IDLE: begin
          cmd_op  <= req.opcode;
          cmd_val <= req_val64[DATA_WIDTH-1:0];
        end
        S_EXEC: begin
          res_popped <= '0;
          res_status <= ST_OK;
          pos        <= '0;
          case (cmd_op)
            OP_PUSH_BACK: begin
              if (full) res_status <= ST_FULL;
              else count <= count + CNT_W'(1);
            end
            OP_PUSH_FRONT: begin
              if (full) begin
                res_status <= ST_FULL;
              end else begin
                count <= count + CNT_W'(1);
                front <= front_dec;
              end
            end
            OP_POP_BACK: begin
              if (empty) res_status <= ST_EMPTY;
              else count <= count - CNT_W'(1);
            end
            OP_POP_FRONT: begin
              if (empty) begin
                res_status <= ST_EMPTY;
              end else begin
                count <= count - CNT_W'(1);
                front <= front_inc;
              end
            end
            OP_ERASE: begin
              if (empty) res_status <= ST_NOT_FOUND;
            end
            default: ;
          endcase
        end
        S_POP: res_popped <= rd64[31:0];
        S_SCAN: begin
          if (match) begin
            if (scan_last) count <= count - CNT_W'(1);
          end else if (scan_last) begin
            res_status <= ST_NOT_FOUND;
          end else begin
            pos <= pos1[CNT_W-1:0];
          end
        end
        S_SHIFT: begin
          if (shift_more) pos <= pos1[CNT_W-1:0];
          else count <= count - CNT_W'(1);
        end
        S_DONE: begin
          if (out_free) begin
            rsp_valid     <= 1'b1;
            rsp.popped    <= res_popped;
            rsp.status    <= res_status;
            rsp.occupancy <= count32[4:0];
          end
        end
        default: ;
      endcase
    end
  end

  // Checks
  `DQE_ASSERT_ALWAYS(a_count_bound, count <= CNT_W'(CAPACITY), "count above capacity")
  `DQE_ASSERT_ALWAYS(a_front_bound, front <= LAST_IDX, "front index out of range")
  `DQE_ASSERT_NEXT(a_accept_exec, req_valid && !req_stall, state == S_EXEC, "accept without exec")
  `DQE_ASSERT_IMPL(a_rsp_from_done, $rose(rsp_valid), $past(state) == S_DONE, "stray response")
  `DQE_ASSERT_NEXT(a_shift_count, state == S_SHIFT && shift_more, count == $past(count),
                   "count moved during shift")

endmodule
